>>> hw/rtl/fhqs_pkg.sv
// shared types, constants and helper functions for the flow hash queue selector
package fhqs_pkg;

  localparam logic [15:0] ETH_VLAN_C  = 16'h8100;
  localparam logic [15:0] ETH_VLAN_S  = 16'h88A8;
  localparam logic [15:0] ETH_IPV4    = 16'h0800;
  localparam logic [15:0] ETH_IPV6    = 16'h86DD;

  localparam logic [4:0]  L3_UNTAGGED = 5'd14;
  localparam logic [4:0]  L3_ONE_TAG  = 5'd18;
  localparam logic [4:0]  L3_TWO_TAGS = 5'd22;

  localparam logic [7:0]  IP_PROTO_TCP = 8'd6;
  localparam logic [7:0]  IP_PROTO_UDP = 8'd17;

  localparam int QIDX_W      = 6;
  localparam int KEY_W       = 64;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef enum logic [1:0] {
    MODE_ZERO,
    MODE_V4,
    MODE_V6
  } mode_t;

  typedef struct packed {
    logic [6:0]        byte_count;
    logic [15:0]       ether_type;
    logic [4:0]        l3_start;
    logic [3:0]        header_words;
    logic [7:0]        protocol;
    logic [1:0][63:0]  src_addr;
    logic [1:0][63:0]  dst_addr;
    logic [15:0]       sport;
    logic [15:0]       dport;
  } frame_t;

  localparam frame_t FRAME_RESET = '{
    byte_count:   7'd0,
    ether_type:   16'd0,
    l3_start:     L3_UNTAGGED,
    header_words: 4'd0,
    protocol:     8'd0,
    src_addr:     '0,
    dst_addr:     '0,
    sport:        16'd0,
    dport:        16'd0
  };

  typedef struct packed {
    mode_t             mode;
    logic [7:0]        protocol;
    logic [15:0]       port;
    logic [1:0][63:0]  src_addr;
    logic [1:0][63:0]  dst_addr;
  } rec_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic almost_full;
  } qstat_t;

  function automatic logic is_vlan(input logic [15:0] t);
    return (t == ETH_VLAN_C) || (t == ETH_VLAN_S);
  endfunction

  function automatic logic [63:0] swap64(input logic [63:0] v);
    logic [63:0] s;
    for (int i = 0; i < 8; i++) begin
      s[8*i +: 8] = v[8*(7-i) +: 8];
    end
    return s;
  endfunction

endpackage

>>> hw/rtl/fhqs_front.sv
// frame parser: captures header fields byte by byte and classifies each finished frame
module fhqs_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  logic [7:0]     data_byte,
  input  logic           last_byte,
  output logic           full,
  input  fhqs_pkg::qstat_t qstat,
  output logic           rec_push,
  output fhqs_pkg::rec_t rec
);

  fhqs_pkg::frame_t frame_r, frame_nxt;
  fhqs_pkg::frame_t snap_r, snap_nxt;
  fhqs_pkg::frame_t cap;
  logic snap_vld_r, snap_vld_nxt;
  logic accept;

  assign full   = qstat.full || (snap_vld_r && qstat.almost_full);
  assign accept = push && !full;

  // per-byte field capture
  always_comb begin
    logic [6:0] p;
    logic [6:0] r;
    logic [6:0] q;
    logic [6:0] l4;
    cap = frame_r;
    p   = frame_r.byte_count;
    r   = '0;
    q   = '0;
    l4  = '0;
    if (p != 7'd127) begin
      cap.byte_count = p + 7'd1;
      if (p == 7'd12) cap.ether_type[15:8] = data_byte;
      if (p == 7'd13) begin
        cap.ether_type[7:0] = data_byte;
        if (fhqs_pkg::is_vlan(cap.ether_type)) cap.l3_start = fhqs_pkg::L3_ONE_TAG;
      end
      if (cap.l3_start == fhqs_pkg::L3_ONE_TAG && p == 7'd16) begin
        cap.ether_type[15:8] = data_byte;
      end
      if (cap.l3_start == fhqs_pkg::L3_ONE_TAG && p == 7'd17) begin
        cap.ether_type[7:0] = data_byte;
        if (fhqs_pkg::is_vlan(cap.ether_type)) cap.l3_start = fhqs_pkg::L3_TWO_TAGS;
      end
      if (cap.l3_start == fhqs_pkg::L3_TWO_TAGS && p == 7'd20) begin
        cap.ether_type[15:8] = data_byte;
      end
      if (cap.l3_start == fhqs_pkg::L3_TWO_TAGS && p == 7'd21) begin
        cap.ether_type[7:0] = data_byte;
      end
      if (p >= {2'b00, cap.l3_start}) begin
        r = p - {2'b00, cap.l3_start};
        if (cap.ether_type == fhqs_pkg::ETH_IPV6) begin
          if (r == 7'd6) cap.protocol = data_byte;
          if (r >= 7'd8 && r < 7'd16) cap.src_addr[0][{r[2:0], 3'b000} +: 8] = data_byte;
          if (r >= 7'd16 && r < 7'd24) cap.src_addr[1][{r[2:0], 3'b000} +: 8] = data_byte;
          if (r >= 7'd24 && r < 7'd32) cap.dst_addr[0][{r[2:0], 3'b000} +: 8] = data_byte;
          if (r >= 7'd32 && r < 7'd40) cap.dst_addr[1][{r[2:0], 3'b000} +: 8] = data_byte;
          l4 = {2'b00, cap.l3_start} + 7'd40;
        end else begin
          if (r == 7'd0) cap.header_words = data_byte[3:0];
          if (r == 7'd9) cap.protocol = data_byte;
          if (r >= 7'd12 && r < 7'd16) cap.src_addr[0][{1'b0, r[1:0], 3'b000} +: 8] = data_byte;
          if (r >= 7'd16 && r < 7'd20) cap.dst_addr[0][{1'b0, r[1:0], 3'b000} +: 8] = data_byte;
          l4 = {2'b00, cap.l3_start} + {1'b0, cap.header_words, 2'b00};
        end
        if (p >= l4) begin
          q = p - l4;
          case (q)
            7'd0:    cap.sport[15:8] = data_byte;
            7'd1:    cap.sport[7:0]  = data_byte;
            7'd2:    cap.dport[15:8] = data_byte;
            7'd3:    cap.dport[7:0]  = data_byte;
            default: ;
          endcase
        end
      end
    end
  end

  always_comb begin
    frame_nxt    = frame_r;
    snap_nxt     = snap_r;
    snap_vld_nxt = accept && last_byte;
    if (accept) begin
      frame_nxt = last_byte ? fhqs_pkg::FRAME_RESET : cap;
      if (last_byte) snap_nxt = cap;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r    <= fhqs_pkg::FRAME_RESET;
      snap_vld_r <= 1'b0;
    end else begin
      frame_r    <= frame_nxt;
      snap_vld_r <= snap_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    snap_r <= snap_nxt;
  end

  // classification of the finished frame
  always_comb begin
    logic [6:0]  n;
    logic [6:0]  l3;
    logic [6:0]  v4_len;
    logic [6:0]  v6_len;
    logic [6:0]  ihl_len;
    logic [6:0]  l4;
    logic        port_ok;
    logic [15:0] big_port;
    n        = snap_r.byte_count;
    l3       = {2'b00, snap_r.l3_start};
    v4_len   = l3 + 7'd20;
    v6_len   = l3 + 7'd40;
    ihl_len  = l3 + {1'b0, snap_r.header_words, 2'b00};
    l4       = (snap_r.ether_type == fhqs_pkg::ETH_IPV6) ? v6_len : ihl_len;
    port_ok  = (snap_r.protocol == fhqs_pkg::IP_PROTO_TCP && n >= l4 + 7'd20) ||
               (snap_r.protocol == fhqs_pkg::IP_PROTO_UDP && n >= l4 + 7'd8);
    big_port = (snap_r.sport > snap_r.dport) ? snap_r.sport : snap_r.dport;

    rec.protocol = snap_r.protocol;
    rec.port     = port_ok ? big_port : 16'd0;
    rec.src_addr = snap_r.src_addr;
    rec.dst_addr = snap_r.dst_addr;
    if (n < 7'd14 || n < l3) begin
      rec.mode = fhqs_pkg::MODE_ZERO;
    end else if (snap_r.ether_type == fhqs_pkg::ETH_IPV4 && n >= v4_len) begin
      if (snap_r.header_words < 4'd5 || n < ihl_len) rec.mode = fhqs_pkg::MODE_ZERO;
      else rec.mode = fhqs_pkg::MODE_V4;
    end else if (snap_r.ether_type == fhqs_pkg::ETH_IPV6 && n >= v6_len) begin
      rec.mode = fhqs_pkg::MODE_V6;
    end else begin
      rec.mode = fhqs_pkg::MODE_ZERO;
    end
  end

  assign rec_push = snap_vld_r;

  a_push_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    accept && last_byte |=> rec_push)
    else $error("finished frame not handed to the queue");

  a_push_only_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    !(accept && last_byte) |=> !rec_push)
    else $error("queue write without a finished frame");

endmodule

>>> hw/rtl/fhqs_queue.sv
// short record queue between the parser and the key pipeline
module fhqs_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  fhqs_pkg::rec_t   wr_rec,
  input  logic             pop,
  output fhqs_pkg::rec_t   rd_rec,
  output fhqs_pkg::qstat_t stat
);

  fhqs_pkg::rec_t mem_r [fhqs_pkg::QUEUE_DEPTH];
  logic [fhqs_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [fhqs_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [fhqs_pkg::QPTR_W:0]   cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_rec;
  end

  assign rd_rec           = mem_r[rd_ptr_r];
  assign stat.empty       = (cnt_r == '0);
  assign stat.full        = (cnt_r == (fhqs_pkg::QPTR_W+1)'(fhqs_pkg::QUEUE_DEPTH));
  assign stat.almost_full = (cnt_r >= (fhqs_pkg::QPTR_W+1)'(fhqs_pkg::QUEUE_DEPTH - 1));

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !stat.full)
    else $error("record queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("record queue underflow");

endmodule

>>> hw/rtl/fhqs_back.sv
// key pipeline: address selection, key sum and byte-wise reduction modulo the queue count
module fhqs_back #(
  parameter int QUEUE_COUNT = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  input  fhqs_pkg::rec_t              rec,
  output logic                        rec_pop,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [fhqs_pkg::QIDX_W-1:0] queue_index
);

  localparam logic [fhqs_pkg::QIDX_W:0] QC = (fhqs_pkg::QIDX_W+1)'(QUEUE_COUNT);
  localparam int NSTG = fhqs_pkg::KEY_W / 8;

  function automatic logic [fhqs_pkg::QIDX_W-1:0] mod_chunk(
    input logic [fhqs_pkg::QIDX_W-1:0] r_in,
    input logic [7:0]                  chunk
  );
    logic [fhqs_pkg::QIDX_W-1:0] r;
    logic [fhqs_pkg::QIDX_W:0]   t;
    r = r_in;
    for (int i = 7; i >= 0; i--) begin
      t = {r, chunk[i]};
      if (t >= QC) t = t - QC;
      r = t[fhqs_pkg::QIDX_W-1:0];
    end
    return r;
  endfunction

  logic en;

  logic                       s0_vld_r;
  logic [fhqs_pkg::KEY_W-1:0] s0_base_r, s0_base_nxt;
  logic [16:0]                s0_add_r, s0_add_nxt;

  logic [NSTG:0]               mv_r;
  logic [fhqs_pkg::KEY_W-1:0]  mkey_r [NSTG+1];
  logic [fhqs_pkg::QIDX_W-1:0] mres_r [NSTG+1];

  assign en      = !mv_r[NSTG] || out_pop;
  assign rec_pop = en && !q_empty;

  // lower address (by wire order for ipv6 only), ipv6 halves summed
  always_comb begin
    logic [127:0] src_sw;
    logic [127:0] dst_sw;
    logic         use_src;
    logic [31:0]  low32;
    src_sw  = {fhqs_pkg::swap64(rec.src_addr[0]), fhqs_pkg::swap64(rec.src_addr[1])};
    dst_sw  = {fhqs_pkg::swap64(rec.dst_addr[0]), fhqs_pkg::swap64(rec.dst_addr[1])};
    use_src = src_sw < dst_sw;
    low32   = (rec.src_addr[0][31:0] < rec.dst_addr[0][31:0]) ?
              rec.src_addr[0][31:0] : rec.dst_addr[0][31:0];
    s0_add_nxt = {9'd0, rec.protocol} + {1'b0, rec.port};
    case (rec.mode)
      fhqs_pkg::MODE_V6: begin
        s0_base_nxt = use_src ? rec.src_addr[0] + rec.src_addr[1]
                              : rec.dst_addr[0] + rec.dst_addr[1];
      end
      fhqs_pkg::MODE_V4: begin
        s0_base_nxt = {32'd0, low32};
      end
      default: begin
        s0_base_nxt = '0;
        s0_add_nxt  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
      mv_r     <= '0;
    end else if (en) begin
      s0_vld_r <= !q_empty;
      mv_r     <= {mv_r[NSTG-1:0], s0_vld_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_base_r <= s0_base_nxt;
      s0_add_r  <= s0_add_nxt;
      mkey_r[0] <= s0_base_r + {{(fhqs_pkg::KEY_W-17){1'b0}}, s0_add_r};
      mres_r[0] <= '0;
    end
  end

  // one key byte per stage, most significant first
  for (genvar k = 0; k < NSTG; k++) begin : g_mod
    always_ff @(posedge clk) begin
      if (en) begin
        mkey_r[k+1] <= mkey_r[k];
        mres_r[k+1] <= mod_chunk(mres_r[k], mkey_r[k][fhqs_pkg::KEY_W-1-8*k -: 8]);
      end
    end
  end

  assign out_empty   = !mv_r[NSTG];
  assign queue_index = mres_r[NSTG];

  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mv_r[NSTG] |-> ({1'b0, mres_r[NSTG]} < QC))
    else $error("queue index not below queue count");

endmodule

>>> hw/rtl/flow_hash_queue_selector_core.sv
// top level of the flow hash queue selector
//
// frames enter one byte per transaction on the input queue port: a byte is
// taken at a rising edge with push high and full low, and in_last_byte marks
// the final byte of a frame. one queue index per frame leaves on the output
// queue port: while empty is low out_queue_index holds the oldest result, and
// it is taken at an edge with pop high.
// a byte is taken every cycle while full is low; full rises only when the
// four-entry record queue, counting a frame finished in the previous cycle,
// has no room left. from the last byte to the result, the frame snapshot is
// taken at the accepting edge, then the record queue write, address selection,
// key sum and modulo reduction (one key byte per stage) are each registered.
// the key pipeline sustains one result per cycle while pop stays high.
// when pop is low and a result waits, the result and pipeline hold, records collect in
// the queue, and the parser keeps taking bytes until the queue runs out of room.
// synchronous reset clears the parser to the start of a frame, drops queued
// records and in-flight results; the block is ready the cycle after reset.
module flow_hash_queue_selector_core #(
  parameter int QUEUE_COUNT = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  output logic                        full,
  input  logic [7:0]                  in_data_byte,
  input  logic                        in_last_byte,
  output logic                        empty,
  input  logic                        pop,
  output logic [fhqs_pkg::QIDX_W-1:0] out_queue_index
);

  fhqs_pkg::rec_t   wr_rec;
  fhqs_pkg::rec_t   rd_rec;
  fhqs_pkg::qstat_t qstat;
  logic             rec_push;
  logic             rec_pop;

  fhqs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .full      (full),
    .qstat     (qstat),
    .rec_push  (rec_push),
    .rec       (wr_rec)
  );

  fhqs_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (rec_push),
    .wr_rec (wr_rec),
    .pop    (rec_pop),
    .rd_rec (rd_rec),
    .stat   (qstat)
  );

  fhqs_back #(
    .QUEUE_COUNT (QUEUE_COUNT)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (qstat.empty),
    .rec         (rd_rec),
    .rec_pop     (rec_pop),
    .out_empty   (empty),
    .out_pop     (pop),
    .queue_index (out_queue_index)
  );

endmodule
